FILE: sv/ssrd_pkg.sv
// shared types, constants and coefficient tables for the scan ray direction block
// no dependencies; used by ssrd_sincos and spherical_scan_ray_direction
package ssrd_pkg;

	localparam int INDEX_BITS_DEF    = 24;
	localparam int ANGLE_BITS_DEF    = 32;
	localparam int OUT_FRAC_BITS_DEF = 16;

	localparam int VC_BITS      = 16;
	localparam int CFG_IDX_BITS = 3;

	// sine/cosine datapath, magnitudes in Q30
	localparam int SC_STEPS   = 7;
	localparam int SIN_STEPS  = 6;
	localparam int SC_LATENCY = 3 + 3 * SC_STEPS + 2;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_HALF    = 31'h2000_0000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THETA_START = 3'd0,
		REG_PHI_START   = 3'd1,
		REG_THETA_STEP  = 3'd2,
		REG_PHI_STEP    = 3'd3,
		REG_CLOCKWISE   = 3'd4,
		REG_VCOUNT      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		logic [30:0] sin_mag;
		logic        sin_neg;
		logic [30:0] cos_mag;
		logic        cos_neg;
	} sc_res_t;

	// horner divisors of the sine series
	function automatic logic [7:0] sin_div(input int k);
		logic [7:0] d;
		case (k)
			0: d = 8'd156;
			1: d = 8'd110;
			2: d = 8'd72;
			3: d = 8'd42;
			4: d = 8'd20;
			5: d = 8'd6;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// horner divisors of the cosine series
	function automatic logic [7:0] cos_div(input int k);
		logic [7:0] d;
		case (k)
			0: d = 8'd182;
			1: d = 8'd132;
			2: d = 8'd90;
			3: d = 8'd56;
			4: d = 8'd30;
			5: d = 8'd12;
			6: d = 8'd2;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/ssrd_sincos.sv
// pipelined sine and cosine of a 32-bit turn angle, magnitudes in Q30 plus signs
// octant fold, horner series with constant divisors; depends on ssrd_pkg
module ssrd_sincos (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [31:0]       angle,
	output logic              out_vld,
	output ssrd_pkg::sc_res_t res
);

	localparam int STEPS = ssrd_pkg::SC_STEPS;

	typedef struct packed {
		logic [29:0]     x;
		logic [29:0]     x2;
		ssrd_pkg::quad_t quad;
		logic            swap;
	} carry_t;

	// floor(v / d) estimate by reciprocal, low by at most one
	function automatic logic [29:0] qest(input logic [29:0] v, input logic [31:0] m);
		logic [61:0] p;
		p = 62'(v) * 62'(m);
		return p[61:32];
	endfunction

	function automatic logic [29:0] qfix(input logic [29:0] v, input logic [29:0] q,
		input logic [7:0] d);
		logic [37:0] r;
		r = 38'(v) - 38'(q) * 38'(d);
		return (r >= 38'(d)) ? q + 30'd1 : q;
	endfunction

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [29:0]           a_s1;
	logic                  swap_s1, swap_s2, swap_s3, swap_s4;
	ssrd_pkg::quad_t       quad_s1, quad_s2, quad_s3, quad_s4;
	logic [61:0]           xm_s2;
	logic [29:0]           x_s3;
	logic [60:0]           xx_s3;
	logic [60:0]           prd_s4;
	logic [30:0]           cf_s4;
	ssrd_pkg::sc_res_t     res_s5;

	carry_t                cr_s [1:STEPS];
	logic                  vl_s [1:STEPS];
	logic [30:0]           hs_s [1:STEPS];
	logic [30:0]           hc_s [1:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vl_s[STEPS];
			vld_s5 <= vld_s4;
		end
	end

	// fold to the first octant, then angle to radians and its square
	always_ff @(posedge clk) begin
		a_s1    <= angle[29] ? 30'(ssrd_pkg::Q30_ONE - {1'b0, angle[29:0]}) : angle[29:0];
		swap_s1 <= angle[29];
		quad_s1 <= ssrd_pkg::quad_t'(angle[31:30]);
		xm_s2   <= 62'(a_s1) * 62'(ssrd_pkg::HALF_PI_Q30) + 62'(ssrd_pkg::Q30_HALF);
		swap_s2 <= swap_s1;
		quad_s2 <= quad_s1;
		x_s3    <= xm_s2[59:30];
		xx_s3   <= 61'(xm_s2[59:30]) * 61'(xm_s2[59:30]) + 61'(ssrd_pkg::Q30_HALF);
		swap_s3 <= swap_s2;
		quad_s3 <= quad_s2;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [7:0]  DC = ssrd_pkg::cos_div(k);
		localparam logic [31:0] RC = 32'((64'd1 << 32) / 64'(DC));

		carry_t      cr_in, cr_s1, cr_s2;
		logic        vl_in, vl_s1, vl_s2;
		logic [30:0] hs_in, hc_in, hs_nx, hc_nx;
		logic [60:0] pc_s1;
		logic [29:0] vc_s2, qc_s2;

		if (k == 0) begin : g_src_head
			assign cr_in = '{x: x_s3, x2: xx_s3[59:30], quad: quad_s3, swap: swap_s3};
			assign vl_in = vld_s3;
			assign hs_in = ssrd_pkg::Q30_ONE;
			assign hc_in = ssrd_pkg::Q30_ONE;
		end else begin : g_src_chain
			assign cr_in = cr_s[k];
			assign vl_in = vl_s[k];
			assign hs_in = hs_s[k];
			assign hc_in = hc_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s1     <= 1'b0;
				vl_s2     <= 1'b0;
				vl_s[k+1] <= 1'b0;
			end else begin
				vl_s1     <= vl_in;
				vl_s2     <= vl_s1;
				vl_s[k+1] <= vl_s2;
			end
		end

		always_ff @(posedge clk) begin
			cr_s1     <= cr_in;
			cr_s2     <= cr_s1;
			cr_s[k+1] <= cr_s2;
			pc_s1     <= 61'(cr_in.x2) * 61'(hc_in);
			vc_s2     <= pc_s1[59:30];
			qc_s2     <= qest(pc_s1[59:30], RC);
			hs_s[k+1] <= hs_nx;
			hc_s[k+1] <= hc_nx;
		end

		assign hc_nx = ssrd_pkg::Q30_ONE - {1'b0, qfix(vc_s2, qc_s2, DC)};

		if (k < ssrd_pkg::SIN_STEPS) begin : g_sin
			localparam logic [7:0]  DS = ssrd_pkg::sin_div(k);
			localparam logic [31:0] RS = 32'((64'd1 << 32) / 64'(DS));
			logic [60:0] ps_s1;
			logic [29:0] vs_s2, qs_s2;

			always_ff @(posedge clk) begin
				ps_s1 <= 61'(cr_in.x2) * 61'(hs_in);
				vs_s2 <= ps_s1[59:30];
				qs_s2 <= qest(ps_s1[59:30], RS);
			end
			assign hs_nx = ssrd_pkg::Q30_ONE - {1'b0, qfix(vs_s2, qs_s2, DS)};
		end else begin : g_sin_pass
			logic [30:0] hp_s1, hp_s2;

			always_ff @(posedge clk) begin
				hp_s1 <= hs_in;
				hp_s2 <= hp_s1;
			end
			assign hs_nx = hp_s2;
		end
	end

	always_ff @(posedge clk) begin
		prd_s4  <= 61'(cr_s[STEPS].x) * 61'(hs_s[STEPS]);
		cf_s4   <= hc_s[STEPS];
		swap_s4 <= cr_s[STEPS].swap;
		quad_s4 <= cr_s[STEPS].quad;
	end

	// undo the octant fold, then place by quadrant
	logic [30:0]       s_oct, sm0, cm0;
	ssrd_pkg::sc_res_t res_nx;

	assign s_oct = prd_s4[60:30];
	assign sm0   = swap_s4 ? cf_s4 : s_oct;
	assign cm0   = swap_s4 ? s_oct : cf_s4;

	always_comb begin
		case (quad_s4)
			ssrd_pkg::QUAD_I:   res_nx = '{sin_mag: sm0, sin_neg: 1'b0, cos_mag: cm0, cos_neg: 1'b0};
			ssrd_pkg::QUAD_II:  res_nx = '{sin_mag: cm0, sin_neg: 1'b0, cos_mag: sm0, cos_neg: 1'b1};
			ssrd_pkg::QUAD_III: res_nx = '{sin_mag: sm0, sin_neg: 1'b1, cos_mag: cm0, cos_neg: 1'b1};
			ssrd_pkg::QUAD_IV:  res_nx = '{sin_mag: cm0, sin_neg: 1'b1, cos_mag: sm0, cos_neg: 1'b0};
			default:            res_nx = '{sin_mag: sm0, sin_neg: 1'b0, cos_mag: cm0, cos_neg: 1'b0};
		endcase
	end

	always_ff @(posedge clk) begin
		res_s5 <= res_nx;
	end

	assign out_vld = vld_s5;
	assign res     = res_s5;

endmodule

FILE: sv/spherical_scan_ray_direction.sv
// throughput: one request per cycle, busy stays low; the pipeline depth is set by the
// one-bit-per-stage index divider and the seven-step series chain in ssrd_sincos
// results leave on done for one cycle each; the receiver cannot stall
// reset clears all valid bits and puts the configuration registers back to their reset values
// top level: index split, angle build, sine/cosine units, product rounding; uses ssrd_pkg
module spherical_scan_ray_direction #(
	parameter int INDEX_BITS    = ssrd_pkg::INDEX_BITS_DEF,
	parameter int ANGLE_BITS    = ssrd_pkg::ANGLE_BITS_DEF,
	parameter int OUT_FRAC_BITS = ssrd_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [INDEX_BITS-1:0]               shot_index,
	input  logic                                cfg_we,
	input  logic [ssrd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ANGLE_BITS-1:0]               cfg_data,
	output logic                                done,
	output logic signed [OUT_FRAC_BITS+1:0]     dir_x,
	output logic signed [OUT_FRAC_BITS+1:0]     dir_y,
	output logic signed [OUT_FRAC_BITS+1:0]     dir_z
);

	localparam int VB    = ssrd_pkg::VC_BITS;
	localparam int OUT_W = OUT_FRAC_BITS + 2;
	localparam int CL    = INDEX_BITS / 2;
	localparam int RL    = VB / 2;
	localparam int SHP   = 60 - OUT_FRAC_BITS;
	localparam int SHZ   = 30 - OUT_FRAC_BITS;
	localparam int LAT   = INDEX_BITS + 3 + ssrd_pkg::SC_LATENCY + 3;
	localparam logic [OUT_FRAC_BITS+2:0] LIM = (OUT_FRAC_BITS+3)'(1) << OUT_FRAC_BITS;
	localparam logic signed [OUT_W-1:0]  POS_LIM = OUT_W'(1) << OUT_FRAC_BITS;
	localparam logic signed [OUT_W-1:0]  NEG_LIM = -POS_LIM;

	// configuration registers
	logic [ANGLE_BITS-1:0] th_start_q, ph_start_q, th_step_q, ph_step_q;
	logic                  cw_q;
	logic [VB-1:0]         vcnt_q, vc_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_start_q <= '0;
			ph_start_q <= '0;
			th_step_q  <= '0;
			ph_step_q  <= '0;
			cw_q       <= 1'b1;
			vcnt_q     <= VB'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ssrd_pkg::REG_THETA_START: th_start_q <= cfg_data;
				ssrd_pkg::REG_PHI_START:   ph_start_q <= cfg_data;
				ssrd_pkg::REG_THETA_STEP:  th_step_q  <= cfg_data;
				ssrd_pkg::REG_PHI_STEP:    ph_step_q  <= cfg_data;
				ssrd_pkg::REG_CLOCKWISE:   cw_q       <= cfg_data[0];
				ssrd_pkg::REG_VCOUNT:      vcnt_q     <= cfg_data[VB-1:0];
				default: ;
			endcase
		end
	end

	assign vc_eff = (vcnt_q == '0) ? VB'(1) : vcnt_q;
	assign busy   = 1'b0;

	// restoring divider, one quotient bit per stage
	logic [INDEX_BITS-1:0] dv_num_s [1:INDEX_BITS];
	logic [VB-1:0]         dv_rem_s [1:INDEX_BITS];
	logic                  dv_vld_s [1:INDEX_BITS];

	for (genvar i = 0; i < INDEX_BITS; i++) begin : g_div
		logic [INDEX_BITS-1:0] num_in;
		logic [VB-1:0]         rem_in;
		logic                  vld_in;
		logic [VB:0]           trial, diff;
		logic                  ge;

		if (i == 0) begin : g_src_head
			assign num_in = shot_index;
			assign rem_in = '0;
			assign vld_in = start & ~busy;
		end else begin : g_src_chain
			assign num_in = dv_num_s[i];
			assign rem_in = dv_rem_s[i];
			assign vld_in = dv_vld_s[i];
		end

		assign trial = {rem_in, num_in[INDEX_BITS-1]};
		assign diff  = trial - {1'b0, vc_eff};
		assign ge    = trial >= {1'b0, vc_eff};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else begin
				dv_vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_num_s[i+1] <= {num_in[INDEX_BITS-2:0], ge};
			dv_rem_s[i+1] <= ge ? diff[VB-1:0] : trial[VB-1:0];
		end
	end

	// angle build: partial products, offsets, then theta start plus or minus offset, phi start plus offset
	logic [INDEX_BITS-1:0] col;
	logic [VB-1:0]         row;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [ANGLE_BITS-1:0] ptl_s1, pth_s1, prl_s1, prh_s1;
	logic [ANGLE_BITS-1:0] thoff_s2, phoff_s2;
	logic [ANGLE_BITS-1:0] theta_s3, phi_s3;
	logic [31:0]           theta_t, phi_t;

	assign col = dv_num_s[INDEX_BITS];
	assign row = dv_rem_s[INDEX_BITS];

	always_ff @(posedge clk) begin
		ptl_s1   <= ANGLE_BITS'(col[CL-1:0] * th_step_q);
		pth_s1   <= ANGLE_BITS'(col[INDEX_BITS-1:CL] * th_step_q);
		prl_s1   <= ANGLE_BITS'(row[RL-1:0] * ph_step_q);
		prh_s1   <= ANGLE_BITS'(row[VB-1:RL] * ph_step_q);
		thoff_s2 <= ptl_s1 + (pth_s1 << CL);
		phoff_s2 <= prl_s1 + (prh_s1 << RL);
		theta_s3 <= cw_q ? th_start_q - thoff_s2 : th_start_q + thoff_s2;
		phi_s3   <= ph_start_q + phoff_s2;
	end

	if (ANGLE_BITS >= 32) begin : g_turn_trunc
		assign theta_t = theta_s3[ANGLE_BITS-1 -: 32];
		assign phi_t   = phi_s3[ANGLE_BITS-1 -: 32];
	end else begin : g_turn_pad
		assign theta_t = {theta_s3, {(32-ANGLE_BITS){1'b0}}};
		assign phi_t   = {phi_s3, {(32-ANGLE_BITS){1'b0}}};
	end

	logic              th_vld, ph_vld;
	ssrd_pkg::sc_res_t th_res, ph_res;

	ssrd_sincos u_theta (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.angle   (theta_t),
		.out_vld (th_vld),
		.res     (th_res)
	);

	ssrd_sincos u_phi (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.angle   (phi_t),
		.out_vld (ph_vld),
		.res     (ph_res)
	);

	// products, rounding half away from zero with saturation, sign
	logic [60:0]              px_s4, py_s4;
	logic [30:0]              pz_s4;
	logic                     nx_s4, ny_s4, nz_s4, nx_s5, ny_s5, nz_s5;
	logic [OUT_FRAC_BITS:0]   mx_s5, my_s5, mz_s5;
	logic signed [OUT_W-1:0]  dir_x_s6, dir_y_s6, dir_z_s6;
	logic [62:0]              rx, ry;
	logic [OUT_FRAC_BITS+2:0] tx, ty;
	logic [OUT_W-1:0]         tz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= dv_vld_s[INDEX_BITS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= th_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign rx = {2'b0, px_s4} + (63'd1 << (SHP - 1));
	assign ry = {2'b0, py_s4} + (63'd1 << (SHP - 1));
	assign tx = rx[62:SHP];
	assign ty = ry[62:SHP];

	if (SHZ > 0) begin : g_z_round
		logic [31:0] rz;
		assign rz = {1'b0, pz_s4} + (32'd1 << (SHZ - 1));
		assign tz = rz[31:SHZ];
	end else begin : g_z_exact
		assign tz = {1'b0, pz_s4};
	end

	always_ff @(posedge clk) begin
		px_s4    <= 61'(ph_res.sin_mag) * 61'(th_res.cos_mag);
		py_s4    <= 61'(ph_res.sin_mag) * 61'(th_res.sin_mag);
		pz_s4    <= ph_res.cos_mag;
		nx_s4    <= ph_res.sin_neg ^ th_res.cos_neg;
		ny_s4    <= ph_res.sin_neg ^ th_res.sin_neg;
		nz_s4    <= ph_res.cos_neg;
		mx_s5    <= (tx > LIM) ? LIM[OUT_FRAC_BITS:0] : tx[OUT_FRAC_BITS:0];
		my_s5    <= (ty > LIM) ? LIM[OUT_FRAC_BITS:0] : ty[OUT_FRAC_BITS:0];
		mz_s5    <= ((OUT_FRAC_BITS+3)'(tz) > LIM) ? LIM[OUT_FRAC_BITS:0] : tz[OUT_FRAC_BITS:0];
		nx_s5    <= nx_s4;
		ny_s5    <= ny_s4;
		nz_s5    <= nz_s4;
		dir_x_s6 <= nx_s5 ? OUT_W'(-{1'b0, mx_s5}) : {1'b0, mx_s5};
		dir_y_s6 <= ny_s5 ? OUT_W'(-{1'b0, my_s5}) : {1'b0, my_s5};
		dir_z_s6 <= nz_s5 ? OUT_W'(-{1'b0, mz_s5}) : {1'b0, mz_s5};
	end

	assign done  = vld_s6;
	assign dir_x = dir_x_s6;
	assign dir_y = dir_y_s6;
	assign dir_z = dir_z_s6;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a request at the pipeline latency");

	a_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[INDEX_BITS] |-> (dv_rem_s[INDEX_BITS] < vc_eff))
		else $error("row index not below the vertical count");

	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		th_vld == ph_vld)
		else $error("theta and phi sine units out of step");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (dir_x <= POS_LIM && dir_x >= NEG_LIM && dir_y <= POS_LIM &&
		dir_y >= NEG_LIM && dir_z <= POS_LIM && dir_z >= NEG_LIM))
		else $error("direction component beyond unit range");

endmodule

FILE: tb/spherical_scan_ray_direction_tb.sv
// testbench for spherical_scan_ray_direction: directed table, then random shots and settings
// checks every direction against a local predictor of the sine/cosine series; uses ssrd_pkg
`timescale 1ns / 1ps

module spherical_scan_ray_direction_tb;

	localparam int IB = ssrd_pkg::INDEX_BITS_DEF;
	localparam int FB = ssrd_pkg::OUT_FRAC_BITS_DEF;
	localparam int OW = FB + 2;
	localparam logic [ssrd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;
	localparam int LIMIT = 400000;
	localparam int DRAIN = IB + 40;

	typedef struct packed {
		logic [OW-1:0] x;
		logic [OW-1:0] y;
		logic [OW-1:0] z;
	} dir_t;

	typedef struct {
		logic [IB-1:0] shot;
		bit            typed;
		dir_t          d;
	} shot_row_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	logic [IB-1:0]     shot_index = '0;
	logic              cfg_we = 0;
	logic [ssrd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0]       cfg_data = '0;
	logic              done;
	logic signed [OW-1:0] dir_x, dir_y, dir_z;

	// shadow of the block's registers
	logic [31:0] theta_start, phi_start, theta_step, phi_step;
	logic        clockwise;
	logic [15:0] vcount;

	dir_t directions_due[$];
	int   errors = 0;
	int   cycles = 0;

	bit   typed_now = 0;
	dir_t typed_dir;

	spherical_scan_ray_direction dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .shot_index(shot_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic void octant_series(input longint unsigned a,
		output longint unsigned s, output longint unsigned c);
		longint unsigned x, x2, h;
		int sdiv[6] = '{156, 110, 72, 42, 20, 6};
		int cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
		x = (a * 64'd1686629713 + (64'd1 << 29)) >> 30;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		h = 64'd1 << 30;
		for (int k = 0; k < 6; k++)
			h = (64'd1 << 30) - (((x2 * h) >> 30) / sdiv[k]);
		s = (x * h) >> 30;
		h = 64'd1 << 30;
		for (int k = 0; k < 7; k++)
			h = (64'd1 << 30) - (((x2 * h) >> 30) / cdiv[k]);
		c = h;
	endfunction

	function automatic void angle_sincos(input logic [31:0] t,
		output longint unsigned sm, output bit sn, output longint unsigned cm, output bit cn);
		longint unsigned r, s, c;
		ssrd_pkg::quad_t q;
		q = ssrd_pkg::quad_t'(t[31:30]);
		r = t[29:0];
		if (r < (64'd1 << 29))
			octant_series(r, s, c);
		else
			octant_series((64'd1 << 30) - r, c, s);   // folded: swap
		case (q)
			ssrd_pkg::QUAD_I:   begin sm = s; sn = 0; cm = c; cn = 0; end
			ssrd_pkg::QUAD_II:  begin sm = c; sn = 0; cm = s; cn = 1; end
			ssrd_pkg::QUAD_III: begin sm = s; sn = 1; cm = c; cn = 1; end
			default:            begin sm = c; sn = 1; cm = s; cn = 0; end
		endcase
	endfunction

	function automatic logic [OW-1:0] round_q(input longint unsigned m, input bit neg,
		input int sh);
		longint unsigned v;
		v = (m + (64'd1 << (sh - 1))) >> sh;
		if (v > (64'd1 << FB))
			v = 64'd1 << FB;
		if (neg)
			v = ~v + 64'd1;
		return v[OW-1:0];
	endfunction

	function automatic dir_t ray_direction(input logic [IB-1:0] shot);
		logic [31:0] col, row, vc, theta, phi, hoff;
		longint unsigned st, ct, sp, cp;
		bit stn, ctn, spn, cpn;
		dir_t d;
		vc = (vcount == 0) ? 32'd1 : 32'(vcount);
		col = 32'(shot) / vc;
		row = 32'(shot) % vc;
		hoff = col * theta_step;
		theta = clockwise ? theta_start - hoff : theta_start + hoff;
		phi = phi_start + row * phi_step;
		angle_sincos(theta, st, stn, ct, ctn);
		angle_sincos(phi, sp, spn, cp, cpn);
		d.x = round_q(sp * ct, spn != ctn, 60 - FB);
		d.y = round_q(sp * st, spn != stn, 60 - FB);
		d.z = round_q(cp, cpn, 30 - FB);
		return d;
	endfunction

	// register shadow, prediction on accepted requests, and result check
	always @(posedge clk or negedge arst_n) begin
		dir_t e;
		if (!arst_n) begin
			theta_start <= '0; phi_start <= '0; theta_step <= '0; phi_step <= '0;
			clockwise <= 1'b1; vcount <= 16'd1;
		end else begin
			if (done) begin
				if (directions_due.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = directions_due.pop_front();
					if (dir_x !== e.x) begin
						$error("dir_x expected %0d got %0d", $signed(e.x), dir_x); errors++;
					end
					if (dir_y !== e.y) begin
						$error("dir_y expected %0d got %0d", $signed(e.y), dir_y); errors++;
					end
					if (dir_z !== e.z) begin
						$error("dir_z expected %0d got %0d", $signed(e.z), dir_z); errors++;
					end
				end
			end
			if (start && !busy)
				directions_due.push_back(ray_direction(shot_index));
			if (cfg_we) begin
				case (cfg_index)
					ssrd_pkg::REG_THETA_START: theta_start <= cfg_data;
					ssrd_pkg::REG_PHI_START:   phi_start <= cfg_data;
					ssrd_pkg::REG_THETA_STEP:  theta_step <= cfg_data;
					ssrd_pkg::REG_PHI_STEP:    phi_step <= cfg_data;
					ssrd_pkg::REG_CLOCKWISE:   clockwise <= cfg_data[0];
					ssrd_pkg::REG_VCOUNT:      vcount <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// a table row with a typed answer must match it as well as the predictor
	always @(posedge clk)
		if (start && !busy && typed_now)
			if (ray_direction(shot_index) !== typed_dir) begin
				$error("typed row: shot %0h disagrees with table", shot_index);
				errors++;
			end

	task automatic drain();
		while (directions_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] ts, input logic [31:0] ps,
		input logic [31:0] tst, input logic [31:0] pst, input logic [31:0] cw,
		input logic [31:0] vc);
		logic [31:0] val[6];
		ssrd_pkg::cfg_reg_t idx[6];
		val = '{ts, ps, tst, pst, cw, vc};
		idx = '{ssrd_pkg::REG_THETA_START, ssrd_pkg::REG_PHI_START, ssrd_pkg::REG_THETA_STEP,
			ssrd_pkg::REG_PHI_STEP, ssrd_pkg::REG_CLOCKWISE, ssrd_pkg::REG_VCOUNT};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1; cfg_index <= idx[i]; cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_shot(input logic [IB-1:0] shot, input int idle_pct,
		input bit typed, input dir_t d);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1; shot_index <= shot; typed_now <= typed; typed_dir <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return {2'($urandom_range(3)), 30'h0} + $urandom_range(2) - 1;
			3: return {3'($urandom_range(7)), 29'h0};
			default: return $urandom;
		endcase
	endfunction

	initial begin
		shot_row_t table_a[$];
		shot_row_t table_b[$];
		dir_t up, none;
		int idle;
		logic [15:0] vc;
		logic [IB-1:0] shot;
		up = '{x: '0, y: '0, z: OW'(1 << FB)};
		none = '{x: '0, y: '0, z: '0};
		// reset settings: every ray points straight up
		table_a = '{'{24'h000000, 1, up}, '{24'hFFFFFF, 1, up}, '{24'hAAAAAA, 1, up},
			'{24'h555555, 1, up}};
		table_b = '{'{24'h000000, 0, none}, '{24'h000001, 0, none}, '{24'h000007, 0, none},
			'{24'h000008, 0, none}, '{24'h00000F, 0, none}, '{24'h000010, 0, none},
			'{24'h7FFFFF, 0, none}, '{24'h800000, 0, none}, '{24'hFFFFFF, 0, none},
			'{24'h123456, 0, none}, '{24'hEDCBA9, 0, none}};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_a[i])
			send_shot(table_a[i].shot, 0, table_a[i].typed, table_a[i].d);
		start <= 1'b0;
		// octant boundary, quarter-turn elevation, counter-clockwise, eight rows
		set_regs(32'h2000_0000, 32'h4000_0000, 32'h1000_0000, 32'h0800_0000, 0, 8);
		foreach (table_b[i]) send_shot(table_b[i].shot, 0, 0, none);
		start <= 1'b0;
		// zero vertical count acts as one; unused register index must be ignored
		set_regs(32'h3FFF_FFFF, 32'hC000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
			32'hABCD_0000);
		cfg_we <= 1'b1; cfg_index <= REG_UNUSED; cfg_data <= 32'hFFFF_FFFF;
		@(posedge clk);
		cfg_we <= 1'b0;
		foreach (table_b[i]) send_shot(table_b[i].shot, 19, 0, none);
		start <= 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: idle = 0;
				1: idle = 57;
				default: idle = 19;
			endcase
			case ($urandom_range(3))
				0: vc = 16'd1;
				1: vc = 16'hFFFF;
				2: vc = 16'($urandom_range(1, 64));
				default: vc = 16'($urandom);
			endcase
			set_regs(rand_angle(), rand_angle(), rand_angle(), rand_angle(), $urandom,
				{16'($urandom_range(65535)), vc});
			for (int n = 0; n < 225; n++) begin
				// mostly shots within the first 32 columns, the rest anywhere
				if ($urandom_range(3) != 0)
					shot = IB'($urandom_range(32 * 32'(vc) > 24'hFFFFFF ? 24'hFFFFFF
						: 32 * 32'(vc) - 1));
				else
					shot = IB'($urandom);
				send_shot(shot, idle, 0, none);
				if (n == 100) begin
					// hold off until every direction is back
					start <= 1'b0;
					@(posedge clk);
					while (directions_due.size() != 0) @(posedge clk);
				end
			end
			start <= 1'b0;
		end

		drain();
		if (errors == 0 && directions_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
